// ===== design/sb2d_pkg.sv =====
// Shared types and constants for the signed binary to decimal ASCII converter.
// No dependencies; used by sb2d_dabble and signed_binary_to_decimal_ascii.
package sb2d_pkg;

  // default value width in bits
  localparam int VALUE_BITS_DEF = 128;

  // ascii codes, six bits wide
  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEGATE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // control from the sequencer to the shared shift-and-correct unit
  typedef struct packed {
    logic load;       // take a new raw value, clear the digits
    logic negate;     // two's-complement the binary register
    logic step;       // one shift-and-add-3 step
    logic shift_dig;  // drop the top decimal digit
  } dab_ctrl_t;

endpackage

// ===== design/sb2d_dabble.sv =====
// Shared shift-and-add-3 unit: binary register, decimal digit register.
// One conversion step per cycle under control of the sequencer. Uses sb2d_pkg.
module sb2d_dabble #(
  parameter int VALUE_BITS = sb2d_pkg::VALUE_BITS_DEF,
  parameter int NDIG       = 39
) (
  input  logic                    clk,
  input  sb2d_pkg::dab_ctrl_t     ctrl,
  input  logic [VALUE_BITS-1:0]   load_value,
  output logic [3:0]              top_digit
);

  localparam int BCD_W = NDIG * 4;

  logic [VALUE_BITS-1:0] bin_r;
  logic [VALUE_BITS-1:0] bin_nxt;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      bcd_nxt;
  logic [BCD_W-1:0]      bcd_fix;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] >= 4'd5) begin
        bcd_fix[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end else begin
        bcd_fix[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  // next values of the two registers
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      bin_nxt = load_value;
      bcd_nxt = '0;
    end else if (ctrl.negate) begin
      bin_nxt = (~bin_r) + {{(VALUE_BITS-1){1'b0}}, 1'b1};
    end else if (ctrl.step) begin
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {bcd_fix[BCD_W-2:0], bin_r[VALUE_BITS-1]};
    end else if (ctrl.shift_dig) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

// ===== design/signed_binary_to_decimal_ascii.sv =====
// Top level of the signed binary to decimal ASCII converter: sequencer and ports.
// Depends on sb2d_pkg and sb2d_dabble.
//
// Usage: present a two's-complement value on in_value_high/in_value_low and
// pulse start while busy is low; the word is taken at that clock edge. Only the
// low VALUE_BITS bits of {in_value_high, in_value_low} count, bit VALUE_BITS-1
// being the sign. The decimal text comes out one character per strobe on
// out_valid, most significant first: '-' for a negative value, then the digits
// with no leading zeros (zero gives one '0'); out_last_char marks the last one.
// Each character is on the ports for exactly one cycle; the receiver cannot stall.
// Sequence: a negate step for a negative value, VALUE_BITS shift-and-add-3
// steps in the shared unit, then the leading zero digits are dropped one at a
// time, then the characters are sent. NDIG is the digit count of the largest
// magnitude (39 at 128 bits).
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// item in flight; no character is sent for it.
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_BITS = sb2d_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        in_value_low,
  input  logic signed [63:0] in_value_high,
  output logic               out_valid,
  output logic [5:0]         out_char_code,
  output logic               out_last_char
);

  // digits of 2^(VALUE_BITS-1): floor((VALUE_BITS-1) * log10(2)) + 1
  localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int REM_W = $clog2(NDIG + 1);

  sb2d_pkg::state_t    state_r;
  sb2d_pkg::state_t    state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [REM_W-1:0]    rem_r;
  logic [REM_W-1:0]    rem_nxt;
  logic                neg_r;
  logic                neg_nxt;
  sb2d_pkg::dab_ctrl_t ctrl;
  logic [127:0]        raw;
  logic [3:0]          top_digit;
  logic                accept;
  logic                step_done;
  logic                skip_more;
  logic                last_dig;

  assign raw       = {in_value_high, in_value_low};
  assign accept    = start && (state_r == sb2d_pkg::ST_IDLE);
  assign step_done = (cnt_r == CNT_W'(VALUE_BITS - 1));
  assign last_dig  = (rem_r == REM_W'(1));
  assign skip_more = (top_digit == 4'd0) && !last_dig;

  // shared shift-and-correct unit
  sb2d_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk        (clk),
    .ctrl       (ctrl),
    .load_value (raw[VALUE_BITS-1:0]),
    .top_digit  (top_digit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sb2d_pkg::ST_IDLE: begin
        if (start) state_nxt = sb2d_pkg::ST_NEGATE;
      end
      sb2d_pkg::ST_NEGATE: begin
        state_nxt = sb2d_pkg::ST_CONVERT;
      end
      sb2d_pkg::ST_CONVERT: begin
        if (step_done) state_nxt = sb2d_pkg::ST_SKIP;
      end
      sb2d_pkg::ST_SKIP: begin
        if (!skip_more) state_nxt = neg_r ? sb2d_pkg::ST_SIGN : sb2d_pkg::ST_EMIT;
      end
      sb2d_pkg::ST_SIGN: begin
        state_nxt = sb2d_pkg::ST_EMIT;
      end
      sb2d_pkg::ST_EMIT: begin
        if (last_dig) state_nxt = sb2d_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sb2d_pkg::ST_IDLE;
      end
    endcase
  end

  // unit control, counters and output word
  always_comb begin
    ctrl          = '0;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    out_valid     = 1'b0;
    out_char_code = sb2d_pkg::CHAR_ZERO;
    out_last_char = 1'b0;
    case (state_r)
      sb2d_pkg::ST_IDLE: begin
        if (accept) begin
          ctrl.load = 1'b1;
          neg_nxt   = raw[VALUE_BITS-1];
          cnt_nxt   = '0;
          rem_nxt   = REM_W'(NDIG);
        end
      end
      sb2d_pkg::ST_NEGATE: begin
        ctrl.negate = neg_r;
      end
      sb2d_pkg::ST_CONVERT: begin
        ctrl.step = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      sb2d_pkg::ST_SKIP: begin
        if (skip_more) begin
          ctrl.shift_dig = 1'b1;
          rem_nxt        = rem_r - REM_W'(1);
        end
      end
      sb2d_pkg::ST_SIGN: begin
        out_valid     = 1'b1;
        out_char_code = sb2d_pkg::CHAR_MINUS;
      end
      sb2d_pkg::ST_EMIT: begin
        out_valid      = 1'b1;
        out_char_code  = sb2d_pkg::CHAR_ZERO + {2'b00, top_digit};
        out_last_char  = last_dig;
        ctrl.shift_dig = 1'b1;
        rem_nxt        = rem_r - REM_W'(1);
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  assign busy = (state_r != sb2d_pkg::ST_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sb2d_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item bookkeeping
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

endmodule

// ===== test/signed_binary_to_decimal_ascii_test.sv =====
// Self-checking testbench for signed_binary_to_decimal_ascii at the default value width.
// Depends on sb2d_pkg and the design; it predicts every character and checks each strobe.
module signed_binary_to_decimal_ascii_test;

  localparam int VALUE_BITS  = sb2d_pkg::VALUE_BITS_DEF;
  localparam int MAX_DIGITS  = 39;
  localparam int RANDOM_WORDS = 108;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 200;

  // one input word and one expected character
  typedef struct {
    logic [127:0] value;
    bit           drain_first;
  } word_t;

  typedef struct packed {
    logic [5:0] char_code;
    logic       last_char;
  } char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [63:0]        in_value_low = '0;
  logic signed [63:0] in_value_high = '0;
  logic               out_valid;
  logic [5:0]         out_char_code;
  logic               out_last_char;

  word_t pending_words[$];
  char_t expected_chars[$];
  bit    accept_seen = 1'b0;
  int    mismatch_count = 0;
  int    presented_count = 0;
  int    cycle_count = 0;

  signed_binary_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value_low (in_value_low),
    .in_value_high(in_value_high),
    .out_valid    (out_valid),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ten to the power p, exact for p up to 38
  function automatic logic [127:0] pow10(input int p);
    logic [127:0] acc;
    acc = 128'd1;
    for (int k = 0; k < p; k++) acc = acc * 128'd10;
    return acc;
  endfunction

  // expected decimal text of one word, appended to the character store
  function automatic void predict_decimal_text(input logic [127:0] raw);
    int unsigned  bits;
    logic [127:0] mask;
    logic [127:0] mag;
    logic         neg;
    int unsigned  digit_buf[MAX_DIGITS + 1];
    int           nd;
    char_t        ch;
    bits = VALUE_BITS;
    if (bits < 1) bits = 1;
    if (bits > 128) bits = 128;
    mask = (bits >= 128) ? {128{1'b1}} : ((128'd1 << bits) - 128'd1);
    mag = raw & mask;
    neg = mag[bits - 1];
    if (neg) mag = (~mag + 128'd1) & mask;
    nd = 0;
    // least significant digit first
    do begin
      digit_buf[nd] = int'(mag % 128'd10);
      mag = mag / 128'd10;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    if (neg) begin
      ch.char_code = sb2d_pkg::CHAR_MINUS;
      ch.last_char = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      ch.char_code = sb2d_pkg::CHAR_ZERO + 6'(digit_buf[k]);
      ch.last_char = (k == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void add_word(input logic [127:0] value, input bit drain_first);
    word_t w;
    w.value = value;
    w.drain_first = drain_first;
    pending_words.push_back(w);
  endfunction

  // random word: full range, narrow magnitudes, decimal boundaries, extremes
  function automatic logic [127:0] random_word();
    logic [127:0] v;
    int           w;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 4))
      0: ;
      1: begin
        w = $urandom_range(1, 127);
        v = v & ((128'd1 << w) - 128'd1);
        if ($urandom_range(0, 1)) v = -v;
      end
      2: begin
        v = pow10($urandom_range(0, 38)) + 128'($urandom_range(0, 2)) - 128'd1;
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        v = {1'b1, 127'd0} + 128'($urandom_range(0, 3)) - 128'd2;
      end
      default: begin
        v = pow10($urandom_range(1, 38)) - 128'd1;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // word accepted: predict its characters
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_decimal_text({in_value_high, in_value_low});
      accept_seen <= 1'b1;
    end else begin
      accept_seen <= 1'b0;
    end
  end

  // driver: hold start until the word is taken, then present the next one
  always @(negedge clk) begin : drive_step
    bit sender_idle;
    bit drain_wait;
    word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !accept_seen)) begin
      sender_idle = (presented_count < 60 || presented_count >= 100) &&
                    ($urandom_range(0, 99) < 10);
      drain_wait = 1'b0;
      if (pending_words.size() > 0)
        drain_wait = pending_words[0].drain_first && (expected_chars.size() != 0 || busy);
      if (pending_words.size() > 0 && !sender_idle && !drain_wait) begin
        w = pending_words.pop_front();
        start <= 1'b1;
        in_value_low <= w.value[63:0];
        in_value_high <= w.value[127:64];
        presented_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe against the oldest expected character
  always @(posedge clk) begin : check_step
    char_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected char: code %0d last %0b", out_char_code, out_last_char);
      end else begin
        want = expected_chars.pop_front();
        if (out_char_code !== want.char_code || out_last_char !== want.last_char) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("char mismatch: expected code %0d last %0b, got code %0d last %0b",
                     want.char_code, want.last_char, out_char_code, out_last_char);
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // stimulus and end of run
  initial begin
    // directed: zero, signs, digit boundaries, extremes, most negative value
    add_word(128'd0, 1'b0);
    add_word(128'd1, 1'b0);
    add_word(-128'd1, 1'b0);
    add_word(128'd9, 1'b0);
    add_word(128'd10, 1'b0);
    add_word(-128'd10, 1'b0);
    add_word(128'd99, 1'b0);
    add_word(128'd100, 1'b0);
    add_word(-128'd9, 1'b0);
    add_word({1'b0, {127{1'b1}}}, 1'b0);
    add_word({1'b1, 127'd0}, 1'b0);
    add_word({1'b1, 126'd0, 1'b1}, 1'b0);
    add_word({64'd0, {64{1'b1}}}, 1'b0);
    add_word({64'd1, 64'd0}, 1'b0);
    add_word(-{64'd1, 64'd0}, 1'b0);
    add_word(pow10(38), 1'b0);
    add_word(pow10(38) - 128'd1, 1'b0);
    add_word(-pow10(38), 1'b0);
    add_word(pow10(19), 1'b0);
    add_word(-(pow10(19) - 128'd1), 1'b0);
    add_word(128'h5555_5555_5555_5555_AAAA_AAAA_AAAA_AAAA, 1'b0);
    add_word(128'hAAAA_AAAA_AAAA_AAAA_5555_5555_5555_5555, 1'b0);
    // random part, with two pauses until the converter drains
    for (int k = 0; k < RANDOM_WORDS; k++)
      add_word(random_word(), (k == 0 || k == 70));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0) begin
      mismatch_count++;
      $display("%0d expected chars never arrived", expected_chars.size());
    end
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
design/sb2d_pkg.sv
design/sb2d_dabble.sv
design/signed_binary_to_decimal_ascii.sv
test/signed_binary_to_decimal_ascii_test.sv
